// File: design/signed_restoring_divider_128_assert.svh
// ----------------------------------------------------------------------------
// signed_restoring_divider_128_assert.svh
// Assertion macros used by the divider's checker file.
// ----------------------------------------------------------------------------
`ifndef SIGNED_RESTORING_DIVIDER_128_ASSERT_SVH
`define SIGNED_RESTORING_DIVIDER_128_ASSERT_SVH

// Concurrent assertion, clocked on clk, quiet while rstn is low.
`define SRD_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion that also holds during reset.
`define SRD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/srd_pkg.sv
// ----------------------------------------------------------------------------
// srd_pkg
// Types and constants of the 128-bit signed restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

package srd_pkg;

  localparam int unsigned Width = 128;
  localparam int unsigned HalfW = Width / 2;
  localparam int unsigned CntW  = $clog2(Width);
  localparam logic [CntW-1:0] LastStep = CntW'(Width - 1);

  typedef enum logic [1:0] {
    SRD_IDLE,
    SRD_NEGATE,
    SRD_DIVIDE,
    SRD_FINISH
  } srd_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic negate;
    logic step;
    logic finish;
  } srd_cmd_t;

endpackage

`default_nettype wire

// File: design/srd_in_if.sv
// ----------------------------------------------------------------------------
// srd_in_if
// Operand request channel: dividend and divisor split in 64-bit halves.
// ----------------------------------------------------------------------------
`default_nettype none

interface srd_in_if
  import srd_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [HalfW-1:0] dividend_high;
  logic        [HalfW-1:0] dividend_low;
  logic signed [HalfW-1:0] divisor_high;
  logic        [HalfW-1:0] divisor_low;

  modport source (
    output valid, dividend_high, dividend_low, divisor_high, divisor_low,
    input  ready
  );
  modport sink (
    input  valid, dividend_high, dividend_low, divisor_high, divisor_low,
    output ready
  );
endinterface

`default_nettype wire

// File: design/srd_out_if.sv
// ----------------------------------------------------------------------------
// srd_out_if
// Result request channel: quotient, remainder and divide-by-zero flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface srd_out_if
  import srd_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [HalfW-1:0] quotient_high;
  logic        [HalfW-1:0] quotient_low;
  logic signed [HalfW-1:0] remainder_high;
  logic        [HalfW-1:0] remainder_low;
  logic                    divide_by_zero;

  modport source (
    output valid, quotient_high, quotient_low, remainder_high, remainder_low,
    output divide_by_zero,
    input  ready
  );
  modport sink (
    input  valid, quotient_high, quotient_low, remainder_high, remainder_low,
    input  divide_by_zero,
    output ready
  );
endinterface

`default_nettype wire

// File: design/srd_datapath.sv
// ----------------------------------------------------------------------------
// srd_datapath
// Operand magnitudes, shift-subtract step and sign fix-up of the results.
// ----------------------------------------------------------------------------
`default_nettype none

module srd_datapath
  import srd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire srd_cmd_t         cmd_i,
  input  wire logic [Width-1:0] dividend_i,
  input  wire logic [Width-1:0] divisor_i,
  output logic      [Width-1:0] quotient_o,
  output logic      [Width-1:0] remainder_o,
  output logic                  divide_by_zero_o
);

  // n_q starts as the dividend; quotient bits fill it from the bottom
  logic [Width-1:0] n_q, n_d;
  logic [Width-1:0] d_q, d_d;
  logic [Width-1:0] r_q, r_d;
  logic             nneg_q, nneg_d;
  logic             dneg_q, dneg_d;
  logic             dz_q, dz_d;
  logic [Width-1:0] quo_q, quo_d;
  logic [Width-1:0] rem_q, rem_d;
  logic             dzr_q, dzr_d;

  logic [Width-1:0] r_shift;
  logic [Width:0]   trial;
  logic             fits;

  // Remainder stays below the divisor magnitude, so the shift never overflows
  assign r_shift = {r_q[Width-2:0], n_q[Width-1]};
  assign trial   = {1'b0, r_shift} - {1'b0, d_q};
  assign fits    = ~trial[Width];

  always_comb begin
    n_d    = n_q;
    d_d    = d_q;
    r_d    = r_q;
    nneg_d = nneg_q;
    dneg_d = dneg_q;
    dz_d   = dz_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dzr_d  = dzr_q;
    if (cmd_i.load) begin
      n_d    = dividend_i;
      d_d    = divisor_i;
      r_d    = '0;
      nneg_d = dividend_i[Width-1];
      dneg_d = divisor_i[Width-1];
      dz_d   = (divisor_i == '0);
    end
    if (cmd_i.negate) begin
      n_d = nneg_q ? (~n_q + Width'(1)) : n_q;
      d_d = dneg_q ? (~d_q + Width'(1)) : d_q;
    end
    if (cmd_i.step) begin
      r_d = fits ? trial[Width-1:0] : r_shift;
      n_d = {n_q[Width-2:0], fits};
    end
    if (cmd_i.finish) begin
      // A zero divisor leaves the dividend magnitude in r, so the remainder
      // comes back as the dividend; only the quotient is forced
      if (dz_q) begin
        quo_d = '1;
      end else if (nneg_q ^ dneg_q) begin
        quo_d = ~n_q + Width'(1);
      end else begin
        quo_d = n_q;
      end
      rem_d = nneg_q ? (~r_q + Width'(1)) : r_q;
      dzr_d = dz_q;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    d_q    <= d_d;
    r_q    <= r_d;
    nneg_q <= nneg_d;
    dneg_q <= dneg_d;
    dz_q   <= dz_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dzr_q  <= dzr_d;
  end

  assign quotient_o       = quo_q;
  assign remainder_o      = rem_q;
  assign divide_by_zero_o = dzr_q;

endmodule

`default_nettype wire

// File: design/srd_ctrl.sv
// ----------------------------------------------------------------------------
// srd_ctrl
// Sequencer: load, sign fix-up, 128 divide steps, result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module srd_ctrl
  import srd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output srd_cmd_t  cmd_o
);

  srd_state_e      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = ~out_valid_q | out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SRD_IDLE:   if (in_valid_i) state_d = SRD_NEGATE;
      SRD_NEGATE: state_d = SRD_DIVIDE;
      SRD_DIVIDE: if (cnt_q == LastStep) state_d = SRD_FINISH;
      SRD_FINISH: if (out_free) state_d = SRD_IDLE;
      default:    state_d = SRD_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    unique case (state_q)
      SRD_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      SRD_NEGATE: begin
        cmd_o.negate = 1'b1;
        cnt_d        = '0;
      end
      SRD_DIVIDE: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + CntW'(1);
      end
      SRD_FINISH: begin
        // hold the finished item until the output register is free
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SRD_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: design/signed_restoring_divider_128.sv
// ----------------------------------------------------------------------------
// signed_restoring_divider_128
// 128-bit two's-complement divider, quotient toward zero, remainder signed
// like the dividend.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries the dividend and divisor as signed high and unsigned low
//   64-bit halves; out_o returns quotient, remainder and a
//   divide_by_zero flag. Both channels use valid/ready.
//   One request is in work at a time. After the request is taken, the
//   divider makes the operand magnitudes, runs the restoring steps (one
//   128-bit subtract a cycle) and then applies the result signs.
//   The result sits in an output register: a new request is taken while an
//   earlier result still waits. If the receiver stalls past the end of the
//   next division, the finished item is held until the register frees.
//   A zero divisor flags divide_by_zero with an all-ones quotient and the
//   dividend as remainder. Reset clears the sequencer and drops any result.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_restoring_divider_128
  import srd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  srd_in_if.sink    in_i,
  srd_out_if.source out_o
);

  srd_cmd_t         cmd;
  logic [Width-1:0] quotient;
  logic [Width-1:0] remainder;

  srd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  srd_datapath u_datapath (
    .clk_i            (clk_i),
    .cmd_i            (cmd),
    .dividend_i       ({in_i.dividend_high, in_i.dividend_low}),
    .divisor_i        ({in_i.divisor_high, in_i.divisor_low}),
    .quotient_o       (quotient),
    .remainder_o      (remainder),
    .divide_by_zero_o (out_o.divide_by_zero)
  );

  assign out_o.quotient_high  = quotient[Width-1:HalfW];
  assign out_o.quotient_low   = quotient[HalfW-1:0];
  assign out_o.remainder_high = remainder[Width-1:HalfW];
  assign out_o.remainder_low  = remainder[HalfW-1:0];

endmodule

`default_nettype wire

// File: design/srd_checker.sv
// ----------------------------------------------------------------------------
// srd_checker
// Port-level checks of the divider, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "signed_restoring_divider_128_assert.svh"

module srd_checker
  import srd_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_i,
  input wire logic             out_valid_i,
  input wire logic             out_ready_i,
  input wire logic [HalfW-1:0] quotient_high_i,
  input wire logic [HalfW-1:0] quotient_low_i,
  input wire logic [HalfW-1:0] remainder_high_i,
  input wire logic [HalfW-1:0] remainder_low_i,
  input wire logic             divide_by_zero_i
);

  logic             in_acc;
  logic             out_stall;
  logic             out_dz;
  logic             quotient_ones;
  logic [4*HalfW:0] result;

  assign in_acc        = in_valid_i & in_ready_i;
  assign out_stall     = out_valid_i & ~out_ready_i;
  assign out_dz        = out_valid_i & divide_by_zero_i;
  assign quotient_ones = &{quotient_high_i, quotient_low_i};
  assign result        = {quotient_high_i, quotient_low_i, remainder_high_i, remainder_low_i,
                          divide_by_zero_i};

  // one request in work: input closes right after a request is taken
  `SRD_ASSERT(a_one_in_flight, clk_i, rst_ni, in_acc |=> !in_ready_i, "request taken while busy")
  // a result never appears the cycle after a request is taken
  `SRD_ASSERT(a_no_early_result, clk_i, rst_ni, in_acc |=> !$rose(out_valid_i), "result too early")
  // stalled result holds its value
  `SRD_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_i && $stable(result), "stall broken")
  // zero divisor forces an all-ones quotient
  `SRD_ASSERT(a_dz_quotient, clk_i, rst_ni, out_dz |-> quotient_ones, "zero divisor quotient wrong")
  // input is open again as soon as a result appears
  `SRD_ASSERT(a_in_reopen, clk_i, rst_ni, $rose(out_valid_i) |-> in_ready_i, "input not reopened")

endmodule

bind signed_restoring_divider_128 srd_checker u_srd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .quotient_high_i  (out_o.quotient_high),
  .quotient_low_i   (out_o.quotient_low),
  .remainder_high_i (out_o.remainder_high),
  .remainder_low_i  (out_o.remainder_low),
  .divide_by_zero_i (out_o.divide_by_zero)
);

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the 128-bit signed restoring divider. Directed divisions cover
// the sign combinations, the extreme operands, a zero divisor and the
// overflow wrap of the most negative value divided by minus one. Random
// divisions of varied operand magnitudes follow. Both sides idle in random
// bursts, except in the last part. Every result is checked field by field
// against an in-order queue of predicted quotients and remainders.
// ----------------------------------------------------------------------------

module tb;

  import srd_pkg::*;

  typedef logic [Width-1:0] word_t;

  typedef struct packed {
    word_t quotient;
    word_t remainder;
    logic  by_zero;
  } quot_rem_t;

  localparam word_t MinValue = {1'b1, {(Width-1){1'b0}}};
  localparam word_t MaxValue = {1'b0, {(Width-1){1'b1}}};
  localparam word_t AllOnes  = {Width{1'b1}};
  localparam word_t One      = word_t'(1);
  localparam word_t Zero     = '0;

  localparam int unsigned CycleLimit = 400_000;
  localparam int unsigned DrainWait  = 140;

  logic clk;
  logic rst_n;

  srd_in_if  in_if ();
  srd_out_if out_if ();

  signed_restoring_divider_128 i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  quot_rem_t   expected_divisions[$];
  bit          idling_on;
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned divisions_sent;
  int unsigned results_checked;
  int unsigned zero_divisors;
  int unsigned negative_quotients;
  int unsigned overflow_wraps;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Truncating division on magnitudes, then fix the signs.
  function automatic quot_rem_t divide_signed(word_t dividend, word_t divisor);
    quot_rem_t res;
    word_t     n_mag;
    word_t     d_mag;
    word_t     q_mag;
    word_t     r_mag;
    logic      n_neg;
    logic      d_neg;
    res.by_zero = 1'b0;
    if (divisor == Zero) begin
      res.quotient  = AllOnes;
      res.remainder = dividend;
      res.by_zero   = 1'b1;
      return res;
    end
    n_neg = dividend[Width-1];
    d_neg = divisor[Width-1];
    n_mag = n_neg ? ~dividend + One : dividend;
    d_mag = d_neg ? ~divisor + One : divisor;
    q_mag = n_mag / d_mag;
    r_mag = n_mag % d_mag;
    res.quotient  = (n_neg != d_neg) ? ~q_mag + One : q_mag;
    res.remainder = n_neg ? ~r_mag + One : r_mag;
    return res;
  endfunction

  // Random magnitude of random bit length, random sign, now and then an extreme.
  function automatic word_t random_operand();
    word_t       value;
    int unsigned bits;
    value = {$urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(0, 15) == 0) begin
      case ($urandom_range(0, 4))
        0: return Zero;
        1: return One;
        2: return AllOnes;
        3: return MinValue;
        default: return MaxValue;
      endcase
    end
    bits  = $urandom_range(1, Width);
    value = value >> (Width - bits);
    if ($urandom_range(0, 1) == 1) value = ~value + One;
    return value;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task automatic send_division(input word_t dividend, input word_t divisor);
    int unsigned gap;
    quot_rem_t   want;
    gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
    if (gap != 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid         <= 1'b1;
    in_if.dividend_high <= dividend[Width-1:HalfW];
    in_if.dividend_low  <= dividend[HalfW-1:0];
    in_if.divisor_high  <= divisor[Width-1:HalfW];
    in_if.divisor_low   <= divisor[HalfW-1:0];
    do @(posedge clk); while (!in_if.ready);
    want = divide_signed(dividend, divisor);
    expected_divisions = {expected_divisions, want};
    divisions_sent++;
    if (want.by_zero) zero_divisors++;
    else if (want.quotient[Width-1]) negative_quotients++;
    if (dividend == MinValue && divisor == AllOnes) overflow_wraps++;
  endtask

  task automatic test_sign_combinations();
    send_division(word_t'(7), word_t'(2));
    send_division(-word_t'(7), word_t'(2));
    send_division(word_t'(7), -word_t'(2));
    send_division(-word_t'(7), -word_t'(2));
    send_division(Zero, word_t'(5));
    send_division(word_t'(5), -word_t'(7));
    send_division(One, AllOnes);
    send_division(AllOnes, One);
    send_division(MaxValue, One);
    send_division(MaxValue, MaxValue);
    send_division(MaxValue, word_t'(3) << 100);
  endtask

  task automatic test_zero_divisor();
    send_division(word_t'(12345), Zero);
    send_division(AllOnes, Zero);
    send_division(Zero, Zero);
    send_division(MinValue, Zero);
  endtask

  task automatic test_most_negative();
    send_division(MinValue, AllOnes);
    send_division(MinValue, One);
    send_division(MinValue, MinValue);
    send_division(MinValue, MaxValue);
    send_division(MaxValue, MinValue);
  endtask

  task automatic test_random_divisions(input int unsigned count);
    idling_on = 1'b1;
    repeat (count) send_division(random_operand(), random_operand());
  endtask

  // Last part: full rate, no gaps on either side.
  task automatic test_back_to_back(input int unsigned count);
    idling_on = 1'b0;
    repeat (count) send_division(random_operand(), random_operand());
  endtask

  initial begin : drive_ready
    int unsigned stall;
    stall = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall == 0 && idling_on && $urandom_range(0, 9) == 0) stall = $urandom_range(1, 19);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    quot_rem_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_divisions.size() == 0) begin
        report_mismatch($sformatf("result with no division pending, quotient %h_%h",
                                  out_if.quotient_high, out_if.quotient_low));
      end else begin
        want = expected_divisions.pop_front();
        if (out_if.quotient_high !== want.quotient[Width-1:HalfW])
          report_mismatch($sformatf("result %0d quotient_high got %h want %h", results_checked,
                                    out_if.quotient_high, want.quotient[Width-1:HalfW]));
        if (out_if.quotient_low !== want.quotient[HalfW-1:0])
          report_mismatch($sformatf("result %0d quotient_low got %h want %h", results_checked,
                                    out_if.quotient_low, want.quotient[HalfW-1:0]));
        if (out_if.remainder_high !== want.remainder[Width-1:HalfW])
          report_mismatch($sformatf("result %0d remainder_high got %h want %h", results_checked,
                                    out_if.remainder_high, want.remainder[Width-1:HalfW]));
        if (out_if.remainder_low !== want.remainder[HalfW-1:0])
          report_mismatch($sformatf("result %0d remainder_low got %h want %h", results_checked,
                                    out_if.remainder_low, want.remainder[HalfW-1:0]));
        if (out_if.divide_by_zero !== want.by_zero)
          report_mismatch($sformatf("result %0d divide_by_zero got %b want %b", results_checked,
                                    out_if.divide_by_zero, want.by_zero));
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("[%0t] timeout with %0d results pending", $realtime, expected_divisions.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_n               = 1'b0;
    idling_on           = 1'b1;
    in_if.valid         = 1'b0;
    in_if.dividend_high = '0;
    in_if.dividend_low  = '0;
    in_if.divisor_high  = '0;
    in_if.divisor_low   = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_sign_combinations();
    test_zero_divisor();
    test_most_negative();
    test_random_divisions(400);
    test_back_to_back(100);

    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_divisions.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    $display("Covered %0d divisions and checked %0d results, %0d mismatches.",
             divisions_sent, results_checked, mismatches);
    $display("Of these: %0d by zero, %0d negative quotients, %0d overflow wraps.",
             zero_divisors, negative_quotients, overflow_wraps);
    if (mismatches == 0 && expected_divisions.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
